// File: rtl/mtkxc_pkg.sv
// ============================================================================
// mtkxc_pkg
// Shared constants, controller states and command/status bundles for the
// MT19937 keystream XOR cipher unit.
// ============================================================================
`default_nettype none

package mtkxc_pkg;

    localparam int WORDS     = 624;
    localparam int SHIFT_OFF = 397;
    localparam int SPLIT     = 227;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 10;
    localparam int DATA_W    = 8;

    localparam logic [WORD_W-1:0] INIT_MULT = 32'h6c078965;
    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908b0df;
    localparam logic [WORD_W-1:0] MID_MASK  = 32'h7ffffffe;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'hff3a58ad;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hffffdf8c;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(WORDS - 1);
    localparam logic [ADDR_W-1:0] WORDS_ADDR = ADDR_W'(WORDS);

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SEED = 1'b0;   // register index, taken from paddr[2]

    typedef enum logic [2:0] {
        ST_SEED_START,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_IDLE,
        ST_CALC
    } state_t;

    typedef struct packed {
        logic seed_start;
        logic seed_mul;
        logic seed_add;
        logic accept;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic seed_last;
        logic out_free;
        logic item_last;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/mtkxc_ram.sv
// ============================================================================
// mtkxc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module mtkxc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mtkxc_ctrl.sv
// ============================================================================
// mtkxc_ctrl
// Controller: sequences the seeding pass and the accept/commit item flow.
// ============================================================================
`default_nettype none

module mtkxc_ctrl
    import mtkxc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    cfg_write,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SEED_START;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SEED_START: state_next = ST_SEED_MUL;
            ST_SEED_MUL:   state_next = ST_SEED_ADD;
            ST_SEED_ADD:   state_next = status.seed_last ? ST_IDLE : ST_SEED_MUL;
            ST_IDLE:       state_next = s_tvalid ? ST_CALC : ST_IDLE;
            ST_CALC: begin
                if (status.out_free) begin
                    state_next = status.item_last ? ST_SEED_START : ST_IDLE;
                end
            end
            default:       state_next = ST_SEED_START;
        endcase
        // a seed write restarts the seeding pass
        if (cfg_write) begin
            state_next = ST_SEED_START;
        end
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_SEED_START: cmd.seed_start = 1'b1;
            ST_SEED_MUL:   cmd.seed_mul   = 1'b1;
            ST_SEED_ADD:   cmd.seed_add   = 1'b1;
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CALC:       cmd.commit     = status.out_free;
            default:       cmd            = '0;
        endcase
    end

    // an item is only worked on after it was taken in idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_CALC))
        else $error("calc state entered without an accepted item");

endmodule

`default_nettype wire

// File: rtl/mtkxc_dp.sv
// ============================================================================
// mtkxc_dp
// Datapath: word store, seed recurrence, on-demand twist, tempering and
// the output register.
// ============================================================================
`default_nettype none

module mtkxc_dp
    import mtkxc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [WORD_W-1:0] seed,
    input  wire logic [DATA_W-1:0] in_data,
    input  wire logic              in_last,
    output logic [DATA_W-1:0]      m_data,
    output logic                   m_last,
    output logic                   m_valid,
    input  wire logic              m_ready
);

    function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                                input logic [WORD_W-1:0] nxt,
                                                input logic [WORD_W-1:0] far);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] mag;
        y   = ((cur ^ nxt) & MID_MASK) ^ cur;
        mag = nxt[0] ? TWIST_XOR : '0;
        return (y >> 1) ^ mag ^ far;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = w;
        r = r ^ (r >> 11);
        r = r ^ ((r & TEMPER_B) << 7);
        r = r ^ ((r & TEMPER_C) << 15);
        r = r ^ (r >> 18);
        return r;
    endfunction

    logic [ADDR_W-1:0] pos_reg, idx_reg;
    logic [WORD_W-1:0] prev_reg, prod_reg, cur_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg, m_valid_reg;

    logic [ADDR_W-1:0] nxt_addr, far_addr, waddr;
    logic [WORD_W-1:0] rd_nxt, rd_far, wdata, twisted, tempered, seed_word;
    logic              we;

    // neighbour and far word of the word at the read position
    assign nxt_addr = (pos_reg == LAST_ADDR) ? '0 : pos_reg + ADDR_W'(1);
    assign far_addr = (pos_reg < ADDR_W'(SPLIT)) ? pos_reg + ADDR_W'(SHIFT_OFF)
                                                 : pos_reg - ADDR_W'(SPLIT);

    assign twisted   = twist(cur_reg, rd_nxt, rd_far);
    assign tempered  = temper(twisted);
    assign seed_word = prod_reg + WORD_W'(idx_reg);

    always_comb begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = twisted;
        if (cmd.seed_start) begin
            we    = 1'b1;
            waddr = '0;
            wdata = seed;
        end else if (cmd.seed_add) begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = seed_word;
        end else if (cmd.commit) begin
            we    = 1'b1;
        end
    end

    mtkxc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_store (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (cmd.accept),
        .raddr_a (nxt_addr),
        .raddr_b (far_addr),
        .rdata_a (rd_nxt),
        .rdata_b (rd_far)
    );

    // cur_reg always mirrors the stored word at pos_reg
    always_ff @(posedge aclk) begin
        if (cmd.seed_start) begin
            prev_reg <= seed;
            cur_reg  <= seed;
            idx_reg  <= ADDR_W'(1);
            pos_reg  <= '0;
        end
        if (cmd.seed_mul) begin
            prod_reg <= INIT_MULT * (prev_reg ^ (prev_reg >> 30));
        end
        if (cmd.seed_add) begin
            prev_reg <= seed_word;
            idx_reg  <= idx_reg + ADDR_W'(1);
        end
        if (cmd.accept) begin
            in_data_reg <= in_data;
            in_last_reg <= in_last;
        end
        if (cmd.commit) begin
            cur_reg    <= rd_nxt;
            pos_reg    <= nxt_addr;
            m_data_reg <= in_data_reg ^ tempered[DATA_W:1];
            m_last_reg <= in_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.seed_last = (idx_reg == LAST_ADDR);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign status.item_last = in_last_reg;

    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;
    assign m_valid = m_valid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwrites one not yet taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_start |=> (pos_reg == '0 && idx_reg == ADDR_W'(1)))
        else $error("seeding did not rewind the keystream position");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit || cmd.accept) |-> (pos_reg <= LAST_ADDR))
        else $error("read position beyond the word store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.seed_add |-> (idx_reg < WORDS_ADDR))
        else $error("seed index beyond the word store");

endmodule

`default_nettype wire

// File: rtl/mt19937_keystream_xor_cipher_unit.sv
// ============================================================================
// mt19937_keystream_xor_cipher_unit
// Byte stream cipher: each item's byte is XORed with bits 8..1 of the next
// tempered MT19937 word; words are twisted one at a time as they are used.
// ============================================================================
// A result is registered at commit, once the item is accepted and the word store
// has read its neighbour and far words together; commit waits for a free output
//   register and writes the twisted word back. s_tready stays low until then.
// Reset and seed writes start a seeding pass (the seed first, then one multiply
//   then one add per further word); s_tready stays low during it. The same
//   pass runs after every item with tlast set, so each buffer restarts.
`default_nettype none

module mt19937_keystream_xor_cipher_unit
    import mtkxc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // [7:0] data_in
    input  wire logic                  s_tlast,   // last_in
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [DATA_W-1:0]     m_tdata,   // [7:0] data_out
    output logic                       m_tlast,   // last_out
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    logic [WORD_W-1:0] seed_reg;
    logic              apb_write, seed_write;
    cmd_t              cmd;
    status_t           status;

    // Seed register: paddr[2] selects the register, only index 0 exists.
    assign pready     = 1'b1;
    assign apb_write  = psel && penable && pwrite && pready;
    assign seed_write = apb_write && (paddr[2] == REG_SEED);
    assign prdata     = (paddr[2] == REG_SEED) ? seed_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (seed_write) begin
            seed_reg <= pwdata;
        end
    end

    mtkxc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (seed_write),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mtkxc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .seed    (seed_reg),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .m_data  (m_tdata),
        .m_last  (m_tlast),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

endmodule

`default_nettype wire

// File: tb/mtkxc_keystream_checker.sv
// ============================================================================
// mtkxc_keystream_checker
// Watches the input stream, the result stream and the APB port of the cipher
// unit. It keeps its own copy of the MT19937 word store, seed and read
// position, works out each expected cipher byte, and compares results in
// order. Failures and outstanding bytes are handed to the testbench top.
// ============================================================================

module mtkxc_keystream_checker
    import mtkxc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [DATA_W-1:0]     s_tdata,   // [7:0] data_in
    input  wire logic                  s_tlast,   // last_in
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [DATA_W-1:0]     m_tdata,   // [7:0] data_out
    input  wire logic                  m_tlast,   // last_out
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic [31:0]           prdata,
    input  wire logic                  pready,
    output int unsigned                mismatch_count,
    output int unsigned                bytes_in_flight
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } cipher_byte_t;

    logic [WORD_W-1:0] key_seed;
    logic [WORD_W-1:0] mt_words [WORDS];
    int unsigned       word_pos;
    cipher_byte_t      expected_bytes [$];
    int unsigned       fail_total = 0;

    function automatic void flag_mismatch(string what);
        fail_total++;
        if (fail_total <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    // Fill the word store from the seed; position 624 = refill pending.
    function automatic void reseed_words();
        logic [WORD_W-1:0] prev;
        mt_words[0] = key_seed;
        for (int i = 1; i < WORDS; i++) begin
            prev        = mt_words[i-1];
            mt_words[i] = WORD_W'(i) + INIT_MULT * (prev ^ (prev >> 30));
        end
        word_pos = WORDS;
    endfunction

    function automatic logic [WORD_W-1:0] twist_word(logic [WORD_W-1:0] cur,
                                                     logic [WORD_W-1:0] nxt,
                                                     logic [WORD_W-1:0] far);
        logic [WORD_W-1:0] y;
        y = ((cur ^ nxt) & MID_MASK) ^ cur;
        return (y >> 1) ^ (nxt[0] ? TWIST_XOR : '0) ^ far;
    endfunction

    // In-place regeneration; the modular indices give the split at 227.
    function automatic void regenerate_words();
        for (int i = 0; i < WORDS; i++) begin
            mt_words[i] = twist_word(mt_words[i], mt_words[(i + 1) % WORDS],
                                     mt_words[(i + SHIFT_OFF) % WORDS]);
        end
        word_pos = 0;
    endfunction

    function automatic logic [WORD_W-1:0] temper_word(logic [WORD_W-1:0] r);
        r ^= r >> 11;
        r ^= (r & TEMPER_B) << 7;
        r ^= (r & TEMPER_C) << 15;
        r ^= r >> 18;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] next_key_byte();
        logic [WORD_W-1:0] t;
        if (word_pos >= WORDS) begin
            regenerate_words();
        end
        t = temper_word(mt_words[word_pos]);
        word_pos++;
        return t[8:1];
    endfunction

    always @(posedge aclk) begin
        cipher_byte_t      want;
        logic [DATA_W-1:0] key;
        if (!aresetn) begin
            key_seed = '0;
            reseed_words();
            expected_bytes.delete();
        end else begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_SEED) begin
                if (pwrite) begin
                    key_seed = pwdata;
                    reseed_words();
                end else if (prdata !== key_seed) begin
                    flag_mismatch($sformatf("seed read: expected %08h, got %08h",
                                            key_seed, prdata));
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h last %0b",
                                            m_tdata, m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last) begin
                        flag_mismatch($sformatf(
                            "byte: expected %02h last %0b, got %02h last %0b",
                            want.data, want.last, m_tdata, m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                key = next_key_byte();
                expected_bytes.push_back('{data: s_tdata ^ key, last: s_tlast});
                // end of buffer: keystream restarts from the seed
                if (s_tlast) begin
                    reseed_words();
                end
            end
        end
        mismatch_count  <= fail_total;
        bytes_in_flight <= expected_bytes.size();
    end

endmodule

// File: tb/mt19937_keystream_xor_cipher_unit_tb.sv
// ============================================================================
// mt19937_keystream_xor_cipher_unit_tb
// Drives the cipher unit with directed and random byte buffers under bursty
// input and a patterned output stall, writes the seed between phases, and
// leaves prediction and comparison to the keystream checker.
// ============================================================================

module mt19937_keystream_xor_cipher_unit_tb;
    import mtkxc_pkg::*;

    // Run ends here regardless.
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned RANDOM_ITEMS = 1130;
    localparam int unsigned LONG_BUFFER  = 700;   // crosses the 624-word refill
    localparam int unsigned HOLD_AFTER   = 400;   // results before the long stall
    localparam int unsigned HOLD_CYCLES  = 400;

    // APB byte addresses: register 0 is the seed, index 1 is unmapped
    localparam logic [APB_ADDR_W-1:0] SEED_ADDR  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    typedef enum logic [1:0] {
        RX_FREE,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE,   // ready a quarter of the time
        RX_CYCLE     // fixed on, on, off pattern
    } rx_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;   // [7:0] data_in
    logic                  s_tlast  = 1'b0; // last_in
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;         // [7:0] data_out
    logic                  m_tlast;         // last_out
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned bytes_in_flight;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 8;
    int unsigned items_sent  = 0;

    mt19937_keystream_xor_cipher_unit dut (.*);

    mtkxc_keystream_checker checker_i (.*);

    // clock: 1 unit high, 1 unit low
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between stall patterns, picked at random. Once,
    // after HOLD_AFTER results, it holds off for a long stretch so the unit
    // backs up and drops s_tready while the sender keeps offering items.
    // ------------------------------------------------------------------------
    initial begin
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned taken;
        int unsigned hold_left;
        int unsigned tick;
        bit          held;
        rx_mode   = RX_FREE;
        mode_left = 0;
        taken     = 0;
        hold_left = 0;
        tick      = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (m_tvalid && m_tready) begin
                taken++;
            end
            if (!held && taken >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. s_tvalid stays high across a burst; between bursts it
    // drops, sometimes for a long gap.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [DATA_W-1:0] data, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(10, 30)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
    endtask

    // one buffer of random bytes, tlast on the final item
    task automatic send_buffer(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_item(DATA_W'($urandom), i == len - 1);
        end
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain_results();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
        end
        do @(posedge aclk); while (bytes_in_flight != 0);
    endtask

    // register access only while idle: results drained, seeding pass over
    task automatic settle_for_config();
        drain_results();
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // read data is checked against the seed by the checker
    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic seed_phase(input logic [31:0] value);
        settle_for_config();
        apb_write(SEED_ADDR, value);
        apb_read(SEED_ADDR);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset seed of zero, readback before any item
        apb_read(SEED_ADDR);

        // data extremes and alternating bits, then end of buffer and restart:
        // the bytes after a tlast item must reuse the keystream from its start
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'haa, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hfe, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);

        // top seed value
        seed_phase(32'hffff_ffff);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'h5a, 1'b1);

        // write to an unmapped register index is ignored: seed unchanged
        settle_for_config();
        apb_write(SPARE_ADDR, 32'h1234_5678);
        apb_read(SEED_ADDR);
        send_item(8'h3c, 1'b0);
        send_item(8'hc3, 1'b1);

        seed_phase(32'd1);
        send_item(8'h7f, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h0f, 1'b0);
        send_item(8'hf0, 1'b1);

        seed_phase(32'h8000_0000);
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);

        // random part: short buffers, one long buffer past the refill point
        // (the long stall lands in it), then more short buffers on new seeds
        seed_phase(32'd5489);
        items_sent = 0;
        while (items_sent < 200) begin
            send_buffer($urandom_range(1, 48));
        end
        send_buffer(LONG_BUFFER);

        seed_phase($urandom);
        while (items_sent < RANDOM_ITEMS - 120) begin
            send_buffer($urandom_range(1, 40));
        end

        seed_phase(32'h0000_0000);
        while (items_sent < RANDOM_ITEMS) begin
            send_buffer($urandom_range(1, 24));
        end

        // let the final results come back, then a short tail for strays
        drain_results();
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0 && bytes_in_flight == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/mtkxc_pkg.sv
rtl/mtkxc_ram.sv
rtl/mtkxc_ctrl.sv
rtl/mtkxc_dp.sv
rtl/mt19937_keystream_xor_cipher_unit.sv
tb/mtkxc_keystream_checker.sv
tb/mt19937_keystream_xor_cipher_unit_tb.sv
